@@ rtl/eofhc_pkg.sv @@
// Package for the EOF container header checker.
// Holds payload structs, parse phase codes, status codes and format constants.
// No dependencies.
package eofhc_pkg;

    // Byte-level format constants
    localparam logic [7:0] MAGIC_BYTE0   = 8'hEF;
    localparam logic [7:0] MAGIC_BYTE1   = 8'h00;
    localparam logic [7:0] VERSION_ONE   = 8'h01;
    localparam logic [7:0] ID_TERMINATOR = 8'h00;
    localparam logic [7:0] ID_CODE       = 8'h01;
    localparam logic [7:0] ID_DATA       = 8'h02;

    localparam logic [3:0] SHANGHAI_REVISION = 4'd11;

    localparam int         BODY_CNT_W   = 18;
    localparam logic [BODY_CNT_W-1:0] BODY_CNT_MAX = {BODY_CNT_W{1'b1}};

    // Parse phases
    localparam logic [2:0] PH_PREFIX0 = 3'd0;
    localparam logic [2:0] PH_PREFIX1 = 3'd1;
    localparam logic [2:0] PH_VERSION = 3'd2;
    localparam logic [2:0] PH_SECT_ID = 3'd3;
    localparam logic [2:0] PH_SIZE_HI = 3'd4;
    localparam logic [2:0] PH_SIZE_LO = 3'd5;
    localparam logic [2:0] PH_BODY    = 3'd6;

    // Verdict codes
    localparam logic [3:0] ST_OK            = 4'd0;
    localparam logic [3:0] ST_PREFIX        = 4'd1;
    localparam logic [3:0] ST_VERSION       = 4'd2;
    localparam logic [3:0] ST_CODE_MISSING  = 4'd3;
    localparam logic [3:0] ST_TWO_DATA      = 4'd4;
    localparam logic [3:0] ST_TWO_CODE      = 4'd5;
    localparam logic [3:0] ST_UNKNOWN_ID    = 4'd6;
    localparam logic [3:0] ST_INCOMPLETE    = 4'd7;
    localparam logic [3:0] ST_ZERO_SIZE     = 4'd8;
    localparam logic [3:0] ST_UNTERMINATED  = 4'd9;
    localparam logic [3:0] ST_BODY_MISMATCH = 4'd10;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] code_length;
        logic [15:0] data_length;
    } out_item_t;

endpackage

@@ rtl/eof_container_header_checker_top.sv @@
// EOF container header checker, top level.
// Depends on eofhc_pkg (types, phase and status codes, format constants).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in      | to block  | in_valid / in_ready  | in_item_t: byte_in, final_byte
//  out     | from block| out_valid / out_ready| out_item_t: status, code_length, data_length
//  cfg     | to block  | cfg_wr_en            | cfg_wr_data: revision (4 bits)
//
// The parse state updates at the edge that accepts a byte. A final byte's verdict is
// registered at that edge too, in the skid entry if one waits, else in the output entry.
// A two-entry output (result register plus skid register) lets bytes keep flowing
// while a verdict waits; in_ready drops only when both entries hold a verdict.
// rst_n clears the parse state, the output entries and sets revision to 11.
// After each verdict the parse state returns to its reset value; revision is kept.
module eof_container_header_checker_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  eofhc_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output eofhc_pkg::out_item_t out_data,
    input  logic                 cfg_wr_en,
    input  logic [3:0]           cfg_wr_data
);
    import eofhc_pkg::*;

    // Configuration
    logic [3:0]            revision_reg;

    // Parse state
    logic [2:0]            phase_reg,      phase_next;
    logic [7:0]            size_hi_reg,    size_hi_next;
    logic                  target_data_reg, target_data_next;
    logic [15:0]           code_size_reg,  code_size_next;
    logic [15:0]           data_size_reg,  data_size_next;
    logic [3:0]            error_reg,      error_next;
    logic [BODY_CNT_W-1:0] body_cnt_reg,   body_cnt_next;

    // Output buffering
    logic                  out_valid_reg;
    out_item_t             out_reg;
    logic                  skid_valid_reg;
    out_item_t             skid_reg;

    logic                  in_fire;
    logic                  produce;
    out_item_t             result;

    // Per-byte evaluation
    logic [3:0]            err;
    logic [3:0]            verdict;
    logic [15:0]           size_word;
    logic [16:0]           size_sum;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign produce   = in_fire && in_data.final_byte;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign size_word = {size_hi_reg, in_data.byte_in};

    always_comb
    begin
        phase_next       = phase_reg;
        size_hi_next     = size_hi_reg;
        target_data_next = target_data_reg;
        code_size_next   = code_size_reg;
        data_size_next   = data_size_reg;
        body_cnt_next    = body_cnt_reg;
        err              = ST_OK;

        // Once an error is latched, remaining bytes are ignored.
        if (error_reg == ST_OK)
        begin
            unique case (phase_reg)
                PH_PREFIX0:
                begin
                    if (in_data.byte_in != MAGIC_BYTE0)
                        err = ST_PREFIX;
                    else
                        phase_next = PH_PREFIX1;
                end
                PH_PREFIX1:
                begin
                    if (in_data.byte_in != MAGIC_BYTE1)
                        err = ST_PREFIX;
                    else
                        phase_next = PH_VERSION;
                end
                PH_VERSION:
                begin
                    if (in_data.byte_in != VERSION_ONE || revision_reg < SHANGHAI_REVISION)
                        err = ST_VERSION;
                    else
                        phase_next = PH_SECT_ID;
                end
                PH_SECT_ID:
                begin
                    priority if (in_data.byte_in == ID_TERMINATOR)
                    begin
                        if (code_size_reg == '0)
                            err = ST_CODE_MISSING;
                        else
                            phase_next = PH_BODY;
                    end
                    else if (in_data.byte_in == ID_DATA)
                    begin
                        if (code_size_reg == '0)
                            err = ST_CODE_MISSING;
                        else if (data_size_reg != '0)
                            err = ST_TWO_DATA;
                        else
                        begin
                            target_data_next = 1'b1;
                            phase_next       = PH_SIZE_HI;
                        end
                    end
                    else if (in_data.byte_in == ID_CODE)
                    begin
                        if (code_size_reg != '0)
                            err = ST_TWO_CODE;
                        else
                        begin
                            target_data_next = 1'b0;
                            phase_next       = PH_SIZE_HI;
                        end
                    end
                    else
                        err = ST_UNKNOWN_ID;
                end
                PH_SIZE_HI:
                begin
                    size_hi_next = in_data.byte_in;
                    phase_next   = PH_SIZE_LO;
                end
                PH_SIZE_LO:
                begin
                    if (size_word == '0)
                        err = ST_ZERO_SIZE;
                    else
                    begin
                        if (target_data_reg)
                            data_size_next = size_word;
                        else
                            code_size_next = size_word;
                        phase_next = PH_SECT_ID;
                    end
                end
                default:
                begin
                    // body byte, saturating count
                    if (body_cnt_reg != BODY_CNT_MAX)
                        body_cnt_next = body_cnt_reg + 1'b1;
                end
            endcase
        end

        error_next = (err != ST_OK) ? err : error_reg;

        // Verdict from the state after this byte
        size_sum = {1'b0, code_size_next} + {1'b0, data_size_next};
        if (error_next != ST_OK)
            verdict = error_next;
        else
        begin
            unique case (phase_next)
                PH_PREFIX0, PH_PREFIX1: verdict = ST_PREFIX;
                PH_VERSION:             verdict = ST_VERSION;
                PH_SIZE_LO:             verdict = ST_INCOMPLETE;
                PH_BODY:                verdict = (body_cnt_next == {1'b0, size_sum}) ?
                                                  ST_OK : ST_BODY_MISMATCH;
                default:                verdict = ST_UNTERMINATED;
            endcase
        end

        result.status      = verdict;
        result.code_length = (verdict == ST_OK) ? code_size_next : 16'd0;
        result.data_length = (verdict == ST_OK) ? data_size_next : 16'd0;

        // A verdict starts a fresh container.
        if (in_data.final_byte)
        begin
            phase_next       = PH_PREFIX0;
            size_hi_next     = '0;
            target_data_next = 1'b0;
            code_size_next   = '0;
            data_size_next   = '0;
            error_next       = ST_OK;
            body_cnt_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            revision_reg    <= SHANGHAI_REVISION;
            phase_reg       <= PH_PREFIX0;
            size_hi_reg     <= '0;
            target_data_reg <= 1'b0;
            code_size_reg   <= '0;
            data_size_reg   <= '0;
            error_reg       <= ST_OK;
            body_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                revision_reg <= cfg_wr_data;
            if (in_fire)
            begin
                phase_reg       <= phase_next;
                size_hi_reg     <= size_hi_next;
                target_data_reg <= target_data_next;
                code_size_reg   <= code_size_next;
                data_size_reg   <= data_size_next;
                error_reg       <= error_next;
                body_cnt_reg    <= body_cnt_next;
            end
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= produce;
            end
            else
                out_valid_reg <= produce;
        end
        else if (produce)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (produce)
                    skid_reg <= result;
            end
            else if (produce)
                out_reg <= result;
        end
        else if (produce)
            skid_reg <= result;
    end

endmodule
